// ===== rtl/stt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    localparam int POSITION_BITS = 16;
    localparam int FIELD_BITS    = 16;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [FIELD_BITS-1:0]    LEN_MAX = {FIELD_BITS{1'b1}};
    localparam logic [15:0]              LIMIT_RESET = 16'd1024;

    // Pending word codes
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_IDENT = 2'd1;
    localparam logic [1:0] PEND_LIT   = 2'd2;

    // Token kinds
    localparam logic [4:0] KIND_IDENT = 5'd0;
    localparam logic [4:0] KIND_LIT   = 5'd1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_QUOTE = 2'd1;
    localparam logic [1:0] STATUS_LIMIT = 2'd2;

    typedef struct packed {
        logic [4:0]            kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic [1:0]            status;
        logic                  run_last;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [4:0] kind;
    } t_punct;

    // Map a punctuation byte to its token kind
    function automatic t_punct punct_lookup(input logic [7:0] c);
        t_punct p;
        p.hit = 1'b1;
        unique case (c)
            8'h3B:   p.kind = 5'd2;   // ;
            8'h28:   p.kind = 5'd3;   // (
            8'h29:   p.kind = 5'd4;   // )
            8'h5B:   p.kind = 5'd5;   // [
            8'h5D:   p.kind = 5'd6;   // ]
            8'h7B:   p.kind = 5'd7;   // {
            8'h7D:   p.kind = 5'd8;   // }
            8'h2E:   p.kind = 5'd9;   // .
            8'h23:   p.kind = 5'd10;  // #
            8'h3D:   p.kind = 5'd11;  // =
            8'h2B:   p.kind = 5'd12;  // +
            8'h2D:   p.kind = 5'd13;  // -
            8'h2A:   p.kind = 5'd14;  // *
            8'h2F:   p.kind = 5'd15;  // /
            8'h3A:   p.kind = 5'd16;  // :
            8'h3F:   p.kind = 5'd17;  // ?
            8'h5E:   p.kind = 5'd18;  // ^
            8'h26:   p.kind = 5'd19;  // &
            8'h7C:   p.kind = 5'd20;  // |
            8'h40:   p.kind = 5'd21;  // @
            default: begin
                p.hit  = 1'b0;
                p.kind = KIND_IDENT;
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/source_text_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming tokenizer: takes one source byte per request and returns tokens
// (kind, start position, length, status). A byte is taken every cycle that
// intake is not paused; each byte yields zero, one or two results, which go
// into a three-entry result queue. Intake pauses while two or more results
// are queued, so a byte that yields two results (punctuation or a quote
// right after a word, or a letter after a literal on the last byte) stalls
// intake; draining one result per cycle, unless the output stalls, sets the
// rate. The token limit register is written through the config channel,
// which is always ready; write it only while no request is in flight.

module source_text_tokenizer
    import stt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte requests
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    // token results
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [4:0]       o_token_kind,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic [1:0]       o_status,
    output logic             o_run_last,
    // token limit register
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_limit;
    logic        go;
    logic        full;
    logic [1:0]  push_n;
    t_result     res0, res1, head;

    // Hold the limit; take a write whenever one is offered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Stall depends only on queue fill, never on the output side this cycle
    assign o_in_stall = full;
    assign go         = i_in_valid && !full;

    stt_lexer u_lexer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (go),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_limit       (r_limit),
        .o_push_n      (push_n),
        .o_res0        (res0),
        .o_res1        (res1)
    );

    stt_rqueue u_rqueue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_head   (head),
        .o_full   (full)
    );

    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_status       = head.status;
    assign o_run_last     = head.run_last;

endmodule

`default_nettype wire

// ===== rtl/stt_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stt_lexer
    import stt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    input  wire logic [15:0] i_limit,
    output logic [1:0]       o_push_n,
    output t_result          o_res0,
    output t_result          o_res1
);

    logic [1:0]               r_pk, n_pk;
    logic [FIELD_BITS-1:0]    r_ps, n_ps;
    logic [FIELD_BITS-1:0]    r_pl, n_pl;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [15:0]              r_te, n_te;
    logic                     r_drop, n_drop;

    t_punct                p;
    logic                  is_letter, is_digit, is_quote;
    logic                  has_pend, pk_ident, extend;
    logic                  e1_close, e1_extlast, e1_newlast, e1, ovf1;
    logic                  e2, e2_word, e2_token, ovf2;
    logic [15:0]           te1, te2;
    logic [FIELD_BITS-1:0] len_inc, pos_f;
    t_result               res1, res2;

    always_comb begin
        p         = punct_lookup(i_text_byte);
        is_letter = (i_text_byte == 8'h5F)
                 || (i_text_byte >= 8'h61 && i_text_byte <= 8'h7A)
                 || (i_text_byte >= 8'h41 && i_text_byte <= 8'h5A);
        is_digit  = i_text_byte >= 8'h30 && i_text_byte <= 8'h39;
        is_quote  = i_text_byte == 8'h27 || i_text_byte == 8'h22;

        has_pend  = r_pk != PEND_NONE;
        pk_ident  = r_pk == PEND_IDENT;
        extend    = (is_letter && pk_ident) || (is_digit && has_pend);
        len_inc   = (r_pl == LEN_MAX) ? r_pl : r_pl + 1'b1;
        pos_f     = FIELD_BITS'(r_pos);

        // First emission: the pending word, closed now or flushed at end of text, or a new one-byte word at end of text
        e1_close   = has_pend && !extend;
        e1_extlast = i_end_of_text && extend;
        e1_newlast = i_end_of_text && !has_pend && (is_letter || is_digit);
        e1         = e1_close || e1_extlast || e1_newlast;
        ovf1       = e1 && (({1'b0, r_te} + 17'd1) >= {1'b0, i_limit});
        te1        = (e1 && !ovf1 && r_te != 16'hFFFF) ? r_te + 16'd1 : r_te;

        res1.kind     = e1_newlast ? (is_letter ? KIND_IDENT : KIND_LIT)
                                   : (pk_ident ? KIND_IDENT : KIND_LIT);
        res1.start    = e1_newlast ? pos_f : r_ps;
        res1.length   = e1_newlast ? FIELD_BITS'(1)
                                   : (e1_extlast ? len_inc : r_pl);
        res1.status   = ovf1 ? STATUS_LIMIT : STATUS_OK;
        res1.run_last = 1'b0;

        // Second emission: punctuation, quote, or a fresh word at end of text
        e2_word  = i_end_of_text && is_letter && has_pend && !pk_ident;
        e2       = !ovf1 && (p.hit || is_quote || e2_word);
        e2_token = e2 && !is_quote;
        ovf2     = e2_token && (({1'b0, te1} + 17'd1) >= {1'b0, i_limit});
        te2      = (e2_token && !ovf2 && te1 != 16'hFFFF) ? te1 + 16'd1 : te1;

        res2.kind     = p.hit ? p.kind : KIND_IDENT;
        res2.start    = pos_f;
        res2.length   = FIELD_BITS'(1);
        res2.status   = is_quote ? STATUS_QUOTE : (ovf2 ? STATUS_LIMIT : STATUS_OK);
        res2.run_last = 1'b1;

        o_push_n = 2'd0;
        o_res0   = res1;
        o_res1   = res2;
        if (i_go && !r_drop) begin
            if (e1) begin
                o_push_n = e2 ? 2'd2 : 2'd1;
                o_res0.run_last = !e2;
            end else if (e2) begin
                o_push_n = 2'd1;
                o_res0   = res2;
            end
        end

        n_pk   = r_pk;
        n_ps   = r_ps;
        n_pl   = r_pl;
        n_pos  = r_pos;
        n_te   = r_te;
        n_drop = r_drop;
        if (i_go) begin
            if (i_end_of_text) begin
                n_pk   = PEND_NONE;
                n_ps   = '0;
                n_pl   = '0;
                n_pos  = '0;
                n_te   = '0;
                n_drop = 1'b0;
            end else if (!r_drop) begin
                n_drop = ovf1 || ovf2 || is_quote;
                n_te   = te2;
                n_pos  = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
                if (extend) begin
                    n_pl = len_inc;
                end else if (is_letter && !ovf1) begin
                    n_pk = PEND_IDENT;
                    n_ps = pos_f;
                    n_pl = FIELD_BITS'(1);
                end else if (is_digit) begin
                    n_pk = PEND_LIT;
                    n_ps = pos_f;
                    n_pl = FIELD_BITS'(1);
                end else begin
                    n_pk = PEND_NONE;
                    n_ps = '0;
                    n_pl = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk   <= PEND_NONE;
            r_ps   <= '0;
            r_pl   <= '0;
            r_pos  <= '0;
            r_te   <= '0;
            r_drop <= 1'b0;
        end else begin
            r_pk   <= n_pk;
            r_ps   <= n_ps;
            r_pl   <= n_pl;
            r_pos  <= n_pos;
            r_te   <= n_te;
            r_drop <= n_drop;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stt_rqueue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stt_rqueue
    import stt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic [1:0] i_push_n,
    input  wire t_result i_res0,
    input  wire t_result i_res1,
    input  wire logic    i_stall,
    output logic         o_valid,
    output t_result      o_head,
    output logic         o_full
);

    localparam int DEPTH = 3;

    t_result    r_q [DEPTH];
    t_result    n_q [DEPTH];
    logic [1:0] r_count, n_count;
    logic [1:0] base;
    logic       pop;

    always_comb begin
        pop  = (r_count != 2'd0) && !i_stall;
        base = r_count - {1'b0, pop};
        n_q  = r_q;
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
        end
        for (int k = 0; k < DEPTH; k++) begin
            if (i_push_n != 2'd0 && base == 2'(k)) begin
                n_q[k] = i_res0;
            end
            if (i_push_n == 2'd2 && base + 2'd1 == 2'(k)) begin
                n_q[k] = i_res1;
            end
        end
        n_count = base + i_push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_valid = r_count != 2'd0;
    assign o_head  = r_q[0];
    assign o_full  = r_count >= 2'd2;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> !o_full)
        else $error("result pushed into a full queue");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_n != 2'd3)
        else $error("more than two results from one byte");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n == 2'd2) |-> (!i_res0.run_last && i_res1.run_last))
        else $error("run_last misplaced in a result pair");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push_n == 2'd0) |=> (r_count == $past(r_count) - 2'd1))
        else $error("queue count did not drop after a pop");

endmodule

`default_nettype wire
